// ===== design/hmca_pkg.sv =====
// Package for the min-max copy apportioner.
// Holds widths, heap entry type, controller states and the command/status structs.
// No dependencies.
package hmca_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int DW         = 20;
  localparam int IDX_W      = $clog2(MAX_GROUPS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CHD_W      = IDX_W + 2;
  localparam int DCNT_W     = $clog2(DW + 1);

  typedef struct packed {
    logic [DW-1:0] size;
    logic [DW-1:0] copies;
    logic [DW-1:0] load;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_UPC, S_AFTER, S_PREP, S_DCHK, S_DROOT,
    S_DIV, S_DNL, S_DNR, S_DNC, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RA_PARENT, RA_ROOT, RA_LEFT, RA_RIGHT
  } rsel_t;

  typedef enum logic [1:0] {
    WS_ENT, WS_RDATA, WS_BEST
  } wsel_t;

  typedef struct packed {
    logic  ins;
    logic  rd_en;
    rsel_t rd_sel;
    logic  wr_en;
    wsel_t wr_sel;
    logic  up_move;
    logic  prep;
    logic  root_take;
    logic  bump;
    logic  div_step;
    logic  div_fin;
    logic  dn_left;
    logic  dn_move;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic parent_lt;
    logic cnt_zero;
    logic stop;
    logic left_oob;
    logic right_in;
    logic best_gt;
    logic div_zero;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/hmca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hmca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/hmca_dp.sv =====
// Datapath: heap RAM, hole registers, restoring divider, output register.
// Depends on hmca_pkg and hmca_ram.
module hmca_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hmca_pkg::cmd_t       cmd,
  output hmca_pkg::sts_t       sts,
  input  logic                 cfg_wr_en,
  input  logic [19:0]          cfg_wr_data,
  input  logic [19:0]          in_group_size,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [19:0]          out_max_load
);
  import hmca_pkg::*;

  logic [DW-1:0]     total_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  idx_r;
  ent_t              ent_r;
  ent_t              lch_r;
  logic [IDX_W-1:0]  lidx_r;
  logic              rvalid_r;
  logic [DW-1:0]     extra_r;
  logic [DW-1:0]     div_rem_r;
  logic [DW-1:0]     div_quo_r;
  logic [DW-1:0]     div_d_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              out_valid_r;
  logic [DW-1:0]     out_load_r;

  ent_t              rdata;
  logic [ENT_W-1:0]  rdata_raw;
  logic [IDX_W-1:0]  parent;
  logic [CHD_W-1:0]  left;
  logic [CHD_W-1:0]  right;
  logic              rsel;
  ent_t              best;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  rd_addr;
  ent_t              wr_data;
  logic [DW:0]       shifted;
  logic [DW:0]       trial;

  assign rdata  = ent_t'(rdata_raw);
  assign parent = (idx_r - IDX_W'(1)) >> 1;
  assign left   = {1'b0, idx_r, 1'b1};
  assign right  = left + CHD_W'(1);
  assign rsel   = rvalid_r && (rdata.load > lch_r.load);
  assign best   = rsel ? rdata : lch_r;
  assign best_idx = rsel ? (lidx_r + IDX_W'(1)) : lidx_r;

  always_comb begin
    case (cmd.rd_sel)
      RA_PARENT: rd_addr = parent;
      RA_ROOT:   rd_addr = '0;
      RA_LEFT:   rd_addr = left[IDX_W-1:0];
      RA_RIGHT:  rd_addr = right[IDX_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WS_ENT:   wr_data = ent_r;
      WS_RDATA: wr_data = rdata;
      WS_BEST:  wr_data = best;
      default:  wr_data = ent_r;
    endcase
  end

  hmca_ram #(.WIDTH(ENT_W), .DEPTH(MAX_GROUPS)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata_raw)
  );

  // one restoring step per cycle
  assign shifted = {div_rem_r, div_quo_r[DW-1]};
  assign trial   = shifted - {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      if (cmd.ins && !sts.full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.emit) begin
        cnt_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      ent_r   <= '{size: in_group_size, copies: DW'(1), load: in_group_size};
      idx_r   <= cnt_r[IDX_W-1:0];
    end
    if (cmd.up_move) begin
      idx_r <= parent;
    end
    if (cmd.prep) begin
      extra_r <= (total_r > DW'(cnt_r)) ? total_r - DW'(cnt_r) : '0;
    end
    if (cmd.root_take) begin
      ent_r <= rdata;
    end
    if (cmd.bump) begin
      ent_r     <= '{size: rdata.size, copies: rdata.copies + DW'(1), load: rdata.load};
      extra_r   <= extra_r - DW'(1);
      div_rem_r <= '0;
      div_quo_r <= rdata.size;
      div_d_r   <= rdata.copies + DW'(1);
      div_cnt_r <= DCNT_W'(DW);
    end
    if (cmd.div_step) begin
      if (!trial[DW]) begin
        div_rem_r <= trial[DW-1:0];
        div_quo_r <= {div_quo_r[DW-2:0], 1'b1};
      end else begin
        div_rem_r <= shifted[DW-1:0];
        div_quo_r <= {div_quo_r[DW-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
    end
    if (cmd.div_fin) begin
      ent_r.load <= div_quo_r + DW'(div_rem_r != '0);
      idx_r      <= '0;
    end
    if (cmd.dn_left) begin
      lch_r    <= rdata;
      lidx_r   <= left[IDX_W-1:0];
      rvalid_r <= right < {1'b0, cnt_r};
    end
    if (cmd.dn_move) begin
      idx_r <= best_idx;
    end
    if (cmd.emit) begin
      out_load_r <= (cnt_r == '0) ? '0 : ent_r.load;
    end
  end

  always_comb begin
    sts.full      = cnt_r == CNT_W'(MAX_GROUPS);
    sts.idx_zero  = idx_r == '0;
    sts.parent_lt = rdata.load < ent_r.load;
    sts.cnt_zero  = cnt_r == '0;
    sts.stop      = (extra_r == '0) || (rdata.load <= DW'(1));
    sts.left_oob  = left >= {1'b0, cnt_r};
    sts.right_in  = right < {1'b0, cnt_r};
    sts.best_gt   = best.load > ent_r.load;
    sts.div_zero  = div_cnt_r == '0;
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_max_load = out_load_r;

endmodule

// ===== design/hmca_ctrl.sv =====
// Controller: sequences insertion sift-up, distribution sift-down and result hand-off.
// Depends on hmca_pkg.
module hmca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_is_last,
  output logic           in_stall,
  input  hmca_pkg::sts_t sts,
  output hmca_pkg::cmd_t cmd
);
  import hmca_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   acc;

  assign acc = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          last_nxt = in_is_last;
          if (!sts.full)       state_nxt = S_UP;
          else if (in_is_last) state_nxt = S_PREP;
        end
      end
      S_UP:    state_nxt = sts.idx_zero ? S_AFTER : S_UPC;
      S_UPC:   state_nxt = sts.parent_lt ? S_UP : S_AFTER;
      S_AFTER: state_nxt = last_r ? S_PREP : S_IDLE;
      S_PREP:  state_nxt = S_DCHK;
      S_DCHK:  state_nxt = S_DROOT;
      S_DROOT: state_nxt = (sts.cnt_zero || sts.stop) ? S_EMIT : S_DIV;
      S_DIV:   if (sts.div_zero) state_nxt = S_DNL;
      S_DNL:   state_nxt = sts.left_oob ? S_DCHK : S_DNR;
      S_DNR:   state_nxt = S_DNC;
      S_DNC:   state_nxt = sts.best_gt ? S_DNL : S_DCHK;
      S_EMIT:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_ROOT;
    cmd.wr_sel = WS_ENT;
    case (state_r)
      S_IDLE: cmd.ins = acc;
      S_UP: begin
        if (sts.idx_zero) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PARENT;
        end
      end
      S_UPC: begin
        cmd.wr_en = 1'b1;
        if (sts.parent_lt) begin
          cmd.wr_sel  = WS_RDATA;
          cmd.up_move = 1'b1;
        end
      end
      S_PREP: cmd.prep = 1'b1;
      S_DCHK: cmd.rd_en = 1'b1;
      S_DROOT: begin
        if (sts.cnt_zero || sts.stop) cmd.root_take = 1'b1;
        else                          cmd.bump      = 1'b1;
      end
      S_DIV: begin
        if (sts.div_zero) cmd.div_fin  = 1'b1;
        else              cmd.div_step = 1'b1;
      end
      S_DNL: begin
        if (sts.left_oob) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LEFT;
        end
      end
      S_DNR: begin
        cmd.dn_left = 1'b1;
        if (sts.right_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_RIGHT;
        end
      end
      S_DNC: begin
        cmd.wr_en = 1'b1;
        if (sts.best_gt) begin
          cmd.wr_sel  = WS_BEST;
          cmd.dn_move = 1'b1;
        end
      end
      S_EMIT:  cmd.emit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// ===== design/heap_minmax_copy_apportioner.sv =====
// Min-max copy apportioner: max-heap of group loads, greedy copy hand-out.
// Load transaction: the group is accepted, then sifted up with one parent read and compare
// per heap level climbed, and written where the climb stops.
// Last transaction: the load, then per handed-out copy a root read, a 20-step divider
// and a sift-down; a final root check and emit put the result out.
// Synchronous active-low reset: heap empty, total_copies 0, no result pending.
module heap_minmax_copy_apportioner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_group_size,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_max_load
);
  import hmca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller owns the input handshake; the datapath owns the result register
  // so a finished result can sit while the next data set loads.
  hmca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Heap lives in one RAM; sifts move a hole instead of swapping pairs.
  hmca_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_group_size (in_group_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_max_load  (out_max_load)
  );

  // Result register is only loaded once the previous result has left.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while held");

  // Quotient taken only after all divider steps.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_fin |-> sts.div_zero)
    else $error("divider result used early");

  // Insert, copy hand-out and emit are mutually exclusive.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins, cmd.bump, cmd.emit}))
    else $error("conflicting heap operations");

  // A result is valid in the cycle after an emit command.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emit lost");

endmodule

// ===== tb/tb_heap_minmax_copy_apportioner.sv =====
// Testbench for heap_minmax_copy_apportioner: directed table, heap-overflow set, random sets.
// Each result is checked against an in-bench greedy apportionment predictor or a typed-in value.
// Depends on hmca_pkg and the heap_minmax_copy_apportioner RTL.
module tb_heap_minmax_copy_apportioner;
  timeunit 1ns;
  timeprecision 1ps;
  import hmca_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_GROUP} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [DW-1:0] value;    // register value or group size
    logic          last;
    logic          typed;    // expected max load typed in below
    logic [DW-1:0] max_exp;
  } stim_row_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [19:0]   cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  logic [19:0]   in_group_size;
  logic          in_is_last;
  logic          out_valid;
  logic          out_stall;
  logic [19:0]   out_max_load;

  // predictor copy of the block: one set of groups and the copy budget
  logic [DW-1:0] grp_size [MAX_GROUPS];
  int unsigned   grp_copies [MAX_GROUPS];
  int unsigned   grp_count;
  logic [DW-1:0] copy_budget;

  logic [DW-1:0] max_load_q [$];
  bit            failed;
  bit            quiet;      // long stretch with no idling on either side

  heap_minmax_copy_apportioner DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_group_size(in_group_size), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_load(out_max_load)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Generous fixed limit; slowest correct run is well under a tenth of this.
  initial begin
    #100ms;
    $display("FAIL heap_minmax_copy_apportioner");
    $finish;
  end

  function automatic int unsigned group_load(int unsigned i);
    int unsigned q;
    q = grp_size[i] / grp_copies[i];
    if (grp_size[i] % grp_copies[i] != 0) q++;
    return q;
  endfunction

  // Greedy hand-out: each spare copy goes to the most loaded group.
  // Ties do not change the answer, so a linear scan stands in for the heap.
  function automatic logic [DW-1:0] apportion_max_load();
    int unsigned spare, best, i;
    spare = (copy_budget > grp_count) ? copy_budget - grp_count : 0;
    best = 0;
    for (i = 1; i < grp_count; i++)
      if (group_load(i) > group_load(best)) best = i;
    while (spare > 0 && grp_count > 0 && group_load(best) > 1) begin
      grp_copies[best]++;
      spare--;
      for (i = 0; i < grp_count; i++)
        if (group_load(i) > group_load(best)) best = i;
    end
    return (grp_count > 0) ? group_load(best) : 0;
  endfunction

  // Accepted group transaction: groups past the heap capacity are dropped.
  function automatic void absorb_group(logic [DW-1:0] size, logic last,
                                       logic typed, logic [DW-1:0] max_exp);
    logic [DW-1:0] m;
    if (grp_count < MAX_GROUPS) begin
      grp_size[grp_count] = size;
      grp_copies[grp_count] = 1;
      grp_count++;
    end
    if (last) begin
      m = apportion_max_load();
      max_load_q.push_back(typed ? max_exp : m);
      grp_count = 0;
    end
  endfunction

  task automatic send_group(logic [DW-1:0] size, logic last,
                            logic typed = 0, logic [DW-1:0] max_exp = '0);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_group_size <= size;
    in_is_last    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_group(size, last, typed, max_exp);
  endtask

  // Register writes only with the block idle: no result pending, then a
  // short pause so the hand-out loop has surely finished.
  task automatic write_budget(logic [DW-1:0] value);
    in_valid <= 1'b0;
    while (max_load_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    copy_budget = value;
  endtask

  // Result side: random stall, compare each accepted transaction in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (max_load_q.size() == 0) begin
          $display("%0t: unexpected max_load, expected none, actual %0d",
                   $time, out_max_load);
          failed = 1;
        end else begin
          if (out_max_load !== max_load_q[0]) begin
            $display("%0t: max_load mismatch, expected %0d, actual %0d",
                     $time, max_load_q[0], out_max_load);
            failed = 1;
          end
          void'(max_load_q.pop_front());
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  stim_row_t dir_rows [] = '{
    '{ROW_CFG,   20'd0,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd0,       1, 1, 20'd0},        // lone empty group
    '{ROW_GROUP, 20'hFFFFF,   1, 1, 20'hFFFFF},    // largest size, no spare copies
    '{ROW_CFG,   20'd1,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd9,       0, 0, 20'd0},        // budget below group count
    '{ROW_GROUP, 20'd4,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd6,       1, 1, 20'd9},
    '{ROW_CFG,   20'd3,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd10,      0, 0, 20'd0},        // tie after one copy
    '{ROW_GROUP, 20'd5,       1, 0, 20'd0},
    '{ROW_CFG,   20'd2,       0, 0, 20'd0},
    '{ROW_GROUP, 20'hFFFFF,   1, 0, 20'd0},
    '{ROW_CFG,   20'hFFFFF,   0, 0, 20'd0},        // loads all reach one, early stop
    '{ROW_GROUP, 20'd5,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd3,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd1,       1, 1, 20'd1},
    '{ROW_GROUP, 20'd0,       0, 0, 20'd0},
    '{ROW_GROUP, 20'd0,       1, 1, 20'd0},
    '{ROW_CFG,   20'd40,      0, 0, 20'd0},
    '{ROW_GROUP, 20'hAAAAA,   0, 0, 20'd0},
    '{ROW_GROUP, 20'h55555,   0, 0, 20'd0},
    '{ROW_GROUP, 20'd7,       1, 0, 20'd0}
  };

  initial begin
    int unsigned n, g, sent, k;
    logic [DW-1:0] sz;
    failed = 0;
    quiet = 0;
    grp_count = 0;
    copy_budget = '0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_valid = 0;
    in_group_size = '0;
    in_is_last = 0;
    out_stall = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_budget(dir_rows[r].value);
      else
        send_group(dir_rows[r].value, dir_rows[r].last,
                   dir_rows[r].typed, dir_rows[r].max_exp);
    end

    // Heap overflow: groups past the capacity are dropped, last still closes.
    write_budget(20'd0);
    for (g = 0; g < MAX_GROUPS + 6; g++)
      send_group((g >= MAX_GROUPS) ? 20'hFFFFF : DW'($urandom_range(1000)),
                 g == MAX_GROUPS + 5);

    // Random sets: mostly a few spare copies, some short budgets, a few huge.
    // A huge budget is never carried over into a set with large sizes.
    sent = 0;
    while (sent < 700) begin
      quiet = (sent >= 300 && sent < 450);
      n = $urandom_range(1, 12);
      k = $urandom_range(99);
      if (k < 8) begin
        write_budget(20'hFFFFF);
      end else if (k < 20) begin
        write_budget(DW'($urandom_range(n)));
      end else if (k < 80 || copy_budget > DW'(1000)) begin
        write_budget(DW'(n + $urandom_range(30)));
      end
      for (g = 0; g < n; g++) begin
        if (k < 8) sz = DW'($urandom_range(16));
        else case ($urandom_range(3))
          0: sz = DW'($urandom_range(20));
          1: sz = DW'($urandom_range(1000));
          2: sz = DW'($urandom);
          default: sz = ($urandom_range(1)) ? 20'hFFFFF : 20'd0;
        endcase
        send_group(sz, g == n - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;
    quiet = 0;

    while (max_load_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed && max_load_q.size() == 0)
      $display("PASS heap_minmax_copy_apportioner");
    else
      $display("FAIL heap_minmax_copy_apportioner");
    $finish;
  end

endmodule

// ===== files.f =====
design/hmca_pkg.sv
design/hmca_ram.sv
design/hmca_dp.sv
design/hmca_ctrl.sv
design/heap_minmax_copy_apportioner.sv
tb/tb_heap_minmax_copy_apportioner.sv
